@@ design/gdd_pkg.sv @@
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared types and constants for the grid dependency dispatcher.
// ----------------------------------------------------------------------------
package gdd_pkg;

   localparam int unsigned DIM_W     = 7;   // holds a grid size of 0..64
   localparam int unsigned COORD_W   = 6;
   localparam int unsigned COUNT_W   = 13;
   localparam int unsigned ADD_W     = 6;   // inner cells counted in one row
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd4096;

   // request actions
   localparam logic [1:0] ACT_PRELOAD  = 2'd0;
   localparam logic [1:0] ACT_START    = 2'd1;
   localparam logic [1:0] ACT_COMPLETE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;

   typedef struct packed {
      logic [1:0]         action;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
   } gdd_req_type;

   typedef struct packed {
      logic               has_cell;
      logic [COORD_W-1:0] ready_x;
      logic [COORD_W-1:0] ready_y;
      logic [COUNT_W-1:0] done_count;
      logic               last;
   } gdd_rsp_type;

   // outcome of walking one row during a scan
   typedef struct packed {
      logic [DIM_W-1:0] first;     // first column not done, clipped to width
      logic [ADD_W-1:0] add;       // inner done cells walked
      logic             dispatch;  // first column is ready
   } gdd_eval_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRELOAD,
      ST_CMP_ROW,
      ST_CMP_LOW,
      ST_CMP_UP,
      ST_CMP_UP_OUT,
      ST_SCAN
   } gdd_state_type;

endpackage

@@ design/gdd_row_mem.sv @@
// ----------------------------------------------------------------------------
// gdd_row_mem
// Done-mark row store: one write port, one read port, registered read data.
// Per-row valid bits make unwritten rows read as zero after reset.
// ----------------------------------------------------------------------------
module gdd_row_mem #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] row_mem_ff [DEPTH];
   logic [WIDTH-1:0] q_ff;
   logic [DEPTH-1:0] vld_ff;
   logic             q_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= row_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         q_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            q_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = q_vld_ff ? q_ff : '0;

endmodule

@@ design/gdd_row_eval.sv @@
// ----------------------------------------------------------------------------
// gdd_row_eval
// Walks one row for the start scan: finds the first cell not done, counts the
// inner done cells before it and checks it against the row below.
// ----------------------------------------------------------------------------
module gdd_row_eval
   import gdd_pkg::*;
#(
   parameter int unsigned WIDTH = 64
) (
   input  logic [WIDTH-1:0] row,
   input  logic [WIDTH-1:0] prev,
   input  logic [DIM_W-1:0] eff_w,
   input  logic             row_zero,
   output gdd_eval_type     ev
);

   localparam int unsigned NG   = (WIDTH + 7) / 8;
   localparam int unsigned IdxW = $clog2(WIDTH);

   logic [NG*8-1:0]  pad;
   logic [NG-1:0]    full;
   logic [2:0]       pos [NG];
   logic [DIM_W-1:0] ones;
   logic [DIM_W-1:0] first;
   logic [IdxW-1:0]  idx;
   logic [IdxW-1:0]  idx_m1;

   // per byte: all ones, and position of the lowest zero
   always_comb begin
      pad = '0;
      pad[WIDTH-1:0] = row;
      for (int g = 0; g < NG; g++) begin
         full[g] = &pad[g*8 +: 8];
         pos[g]  = 3'd7;
         for (int b = 7; b >= 0; b--) begin
            if (!pad[g*8 + b]) begin
               pos[g] = 3'(b);
            end
         end
      end
   end

   // lowest byte that holds a zero
   always_comb begin
      ones = DIM_W'(NG * 8);
      for (int g = NG - 1; g >= 0; g--) begin
         if (!full[g]) begin
            ones = DIM_W'(g * 8) + {4'b0, pos[g]};
         end
      end
   end

   assign first  = (ones < eff_w) ? ones : eff_w;
   assign idx    = first[IdxW-1:0];
   assign idx_m1 = idx - 1'b1;

   assign ev.first    = first;
   assign ev.dispatch = (first < eff_w) && (first != '0) && !row_zero &&
                        prev[idx] && prev[idx_m1];
   assign ev.add      = (!row_zero && first != '0) ? ADD_W'(first - 1'b1) : '0;

endmodule

@@ design/grid_dependency_dispatcher.sv @@
// ----------------------------------------------------------------------------
// grid_dependency_dispatcher
// Done-mark tracker for a 2-D grid; dispatches cells whose left, lower and
// diagonal neighbours are done.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every item gives one
// or more results, each shown for a single cycle with rsp_valid; the last
// one carries rsp_data.last. Results cannot be held off, so the receiver must
// take each in the cycle it appears. The first result shows in the cycle after
// the cycle that produces it, and busy may already be low by then.
// The steps follow from the single read port of the row store:
//   preload        - read the row, then write it back
//   complete       - rows y, y-1, y+1 read in turn, plus ST_CMP_UP_OUT when both
//                    neighbours are dispatched
//   start scan     - one row per cycle, two passes (count, then dispatch);
//                    an empty grid answers at once
//   anything else  - answered in the accept cycle, busy stays low
// The row store needs no clearing pass: per-row valid bits are cleared by
// reset. Configuration may only be written while busy is low and no result is
// still to come; csr_ready is always high.
// ----------------------------------------------------------------------------
module grid_dependency_dispatcher
   import gdd_pkg::*;
#(
   parameter int unsigned MAX_DIM = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   // request
   input  logic                 start,
   output logic                 busy,
   input  gdd_req_type          req_data,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   // results
   output logic                 rsp_valid,
   output gdd_rsp_type          rsp_data
);

   localparam int unsigned    IdxW   = $clog2(MAX_DIM);
   localparam logic [DIM_W-1:0] DimMax = DIM_W'(MAX_DIM);

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] total,
                                                  input logic [ADD_W-1:0]   inc);
      logic [COUNT_W:0] sum;
      sum = {1'b0, total} + {{(COUNT_W + 1 - ADD_W){1'b0}}, inc};
      return (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
   endfunction

   // state
   gdd_state_type        state_ff, state_in;
   logic [DIM_W-1:0]     width_ff, width_in;
   logic [DIM_W-1:0]     height_ff, height_in;
   gdd_req_type          item_ff, item_in;
   logic [MAX_DIM-1:0]   rowy_ff, rowy_in;    // completed cell's row, mark set
   logic [MAX_DIM-1:0]   low_ff, low_in;      // row below it
   logic [MAX_DIM-1:0]   prev_ff, prev_in;    // scan: row below current
   logic [DIM_W-1:0]     row_ff, row_in;      // scan row
   logic [DIM_W-1:0]     last_row_ff, last_row_in;
   logic                 any_ff, any_in;
   logic                 pass_ff, pass_in;    // 0 counting, 1 dispatching
   logic [COUNT_W-1:0]   total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   gdd_rsp_type          rsp_ff, rsp_in;

   // row store
   logic                 mem_rd_en;
   logic [IdxW-1:0]      mem_rd_addr;
   logic [MAX_DIM-1:0]   mem_rd_data;
   logic                 mem_wr_en;
   logic [IdxW-1:0]      mem_wr_addr;
   logic [MAX_DIM-1:0]   mem_wr_data;

   // derived
   logic [DIM_W-1:0]     eff_w, eff_h;
   logic                 req_inside;
   logic [MAX_DIM-1:0]   set_row;
   logic [DIM_W-1:0]     x_p1, y_p1, row_next;
   logic [COORD_W-1:0]   x_m1, y_m1;
   logic                 right_ok, up_ok;
   gdd_eval_type         ev;

   // result being produced this cycle
   logic                 emit;
   logic                 emit_has;
   logic [COORD_W-1:0]   emit_x, emit_y;
   logic                 emit_last;

   gdd_row_mem #(
      .DEPTH (MAX_DIM),
      .WIDTH (MAX_DIM)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   gdd_row_eval #(
      .WIDTH (MAX_DIM)
   ) u_eval (
      .row      (mem_rd_data),
      .prev     (prev_ff),
      .eff_w    (eff_w),
      .row_zero (row_ff == '0),
      .ev       (ev)
   );

   // registers above MAX_DIM act as MAX_DIM
   assign eff_w = (width_ff  > DimMax) ? DimMax : width_ff;
   assign eff_h = (height_ff > DimMax) ? DimMax : height_ff;

   assign req_inside = ({1'b0, req_data.cell_x} < eff_w) &&
                       ({1'b0, req_data.cell_y} < eff_h);

   // read row with the item's mark added (preload and complete)
   assign set_row = mem_rd_data |
                    ({{(MAX_DIM-1){1'b0}}, 1'b1} << item_ff.cell_x[IdxW-1:0]);

   assign x_p1     = {1'b0, item_ff.cell_x} + 1'b1;
   assign y_p1     = {1'b0, item_ff.cell_y} + 1'b1;
   assign x_m1     = item_ff.cell_x - 1'b1;
   assign y_m1     = item_ff.cell_y - 1'b1;
   assign row_next = row_ff + 1'b1;

   // right neighbour (x+1,y): left is the cell just completed
   assign right_ok = (x_p1 < eff_w) && (item_ff.cell_y != '0) &&
                     !rowy_ff[x_p1[IdxW-1:0]] &&
                     low_ff[x_p1[IdxW-1:0]] && low_ff[item_ff.cell_x[IdxW-1:0]];

   // upper neighbour (x,y+1): row y+1 is on the read port in ST_CMP_UP
   assign up_ok = (y_p1 < eff_h) && (item_ff.cell_x != '0) &&
                  !mem_rd_data[item_ff.cell_x[IdxW-1:0]] &&
                  mem_rd_data[x_m1[IdxW-1:0]] && rowy_ff[x_m1[IdxW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= DimMax;
         height_ff    <= DimMax;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         any_ff       <= 1'b0;
         pass_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         any_ff       <= any_in;
         pass_ff      <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rowy_ff     <= rowy_in;
      low_ff      <= low_in;
      prev_ff     <= prev_in;
      row_ff      <= row_in;
      last_row_ff <= last_row_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in    = state_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      item_in     = item_ff;
      rowy_in     = rowy_ff;
      low_in      = low_ff;
      prev_in     = prev_ff;
      row_in      = row_ff;
      last_row_in = last_row_ff;
      any_in      = any_ff;
      pass_in     = pass_ff;
      total_in    = total_ff;

      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = item_ff.cell_y[IdxW-1:0];
      mem_wr_data = set_row;

      emit      = 1'b0;
      emit_has  = 1'b0;
      emit_x    = '0;
      emit_y    = '0;
      emit_last = 1'b1;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  width_in  = csr_wdata;
            CSR_GRID_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in     = req_data;
               mem_rd_addr = req_data.cell_y[IdxW-1:0];
               unique case (req_data.action)
                  ACT_PRELOAD: begin
                     if (req_inside) begin
                        mem_rd_en = 1'b1;
                        state_in  = ST_PRELOAD;
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  ACT_COMPLETE: begin
                     if (req_inside) begin
                        mem_rd_en = 1'b1;
                        state_in  = ST_CMP_ROW;
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  ACT_START: begin
                     if (eff_h != '0) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        row_in      = '0;
                        pass_in     = 1'b0;
                        any_in      = 1'b0;
                        state_in    = ST_SCAN;
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end

         ST_PRELOAD: begin
            mem_wr_en = 1'b1;
            emit      = 1'b1;
            state_in  = ST_IDLE;
         end

         ST_CMP_ROW: begin
            // write back row y while row y-1 is fetched: different entries
            mem_wr_en   = 1'b1;
            rowy_in     = set_row;
            total_in    = sat_add(total_ff, ADD_W'(1));
            mem_rd_en   = (item_ff.cell_y != '0);
            mem_rd_addr = y_m1[IdxW-1:0];
            state_in    = ST_CMP_LOW;
         end

         ST_CMP_LOW: begin
            low_in      = mem_rd_data;
            mem_rd_en   = (y_p1 < eff_h);
            mem_rd_addr = y_p1[IdxW-1:0];
            state_in    = ST_CMP_UP;
         end

         ST_CMP_UP: begin
            emit     = 1'b1;
            state_in = ST_IDLE;
            if (right_ok) begin
               emit_has  = 1'b1;
               emit_x    = x_p1[COORD_W-1:0];
               emit_y    = item_ff.cell_y;
               emit_last = !up_ok;
               if (up_ok) begin
                  state_in = ST_CMP_UP_OUT;
               end
            end else if (up_ok) begin
               emit_has = 1'b1;
               emit_x   = item_ff.cell_x;
               emit_y   = y_p1[COORD_W-1:0];
            end
         end

         ST_CMP_UP_OUT: begin
            emit     = 1'b1;
            emit_has = 1'b1;
            emit_x   = item_ff.cell_x;
            emit_y   = y_p1[COORD_W-1:0];
            state_in = ST_IDLE;
         end

         ST_SCAN: begin
            prev_in     = mem_rd_data;
            mem_rd_addr = row_next[IdxW-1:0];
            if (!pass_ff) begin
               // counting pass: final count and last dispatching row
               total_in = sat_add(total_ff, ev.add);
               if (ev.dispatch) begin
                  last_row_in = row_ff;
                  any_in      = 1'b1;
               end
               if (row_next < eff_h) begin
                  mem_rd_en = 1'b1;
                  row_in    = row_next;
               end else if (any_in) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
                  row_in      = '0;
                  pass_in     = 1'b1;
               end else begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               // dispatch pass: rows are unchanged, so the same rows fire
               if (ev.dispatch) begin
                  emit      = 1'b1;
                  emit_has  = 1'b1;
                  emit_x    = ev.first[COORD_W-1:0];
                  emit_y    = row_ff[COORD_W-1:0];
                  emit_last = (row_ff == last_row_ff);
               end
               if (ev.dispatch && row_ff == last_row_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_rd_en = 1'b1;
                  row_in    = row_next;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in       = emit;
      rsp_in.has_cell    = emit_has;
      rsp_in.ready_x     = emit_x;
      rsp_in.ready_y     = emit_y;
      rsp_in.done_count  = total_in;
      rsp_in.last        = emit_last;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/gdd_checker.sv @@
// ----------------------------------------------------------------------------
// gdd_checker
// Port-level checks for the grid dependency dispatcher, bound to the top.
// ----------------------------------------------------------------------------
module gdd_checker
   import gdd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input gdd_rsp_type rsp_data
);

   // an accepted item either keeps the block busy or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted item neither busy nor answered");

   // an empty result is always the only one of its item, with zero coordinates
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_cell |->
         rsp_data.last && rsp_data.ready_x == '0 && rsp_data.ready_y == '0)
      else $error("empty result not last or carries coordinates");

   // more results to come means the item is still in progress
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("non-last result while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.done_count <= COUNT_MAX)
      else $error("done count beyond saturation");

endmodule

bind grid_dependency_dispatcher gdd_checker u_gdd_checker (.*);
